// ----- sv/mrtu_pkg.sv -----
// Shared types, codes and the CRC-16 byte update for the Modbus RTU master.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

  localparam int MAX_REGS = 125;
  localparam int CNT_LIM_RAW = (MAX_REGS > 125) ? 125 : MAX_REGS;
  localparam logic [6:0] CNT_LIM = 7'((CNT_LIM_RAW < 1) ? 1 : CNT_LIM_RAW);

  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_SINGLE = 3'd1;
  localparam logic [2:0] MODE_MULTI  = 3'd2;
  localparam logic [2:0] MODE_WORD   = 3'd3;
  localparam logic [2:0] MODE_RX     = 3'd4;
  localparam logic [2:0] MODE_TICK   = 3'd5;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [7:0] FUNC_READ   = 8'h03;
  localparam logic [7:0] FUNC_SINGLE = 8'h06;
  localparam logic [7:0] FUNC_MULTI  = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic CFG_SLAVE_ID = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] start_addr;
    logic [6:0]  reg_count;
    logic [15:0] word_value;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       last;
  } out_t;

  typedef struct packed {
    logic            is_tx;
    logic            frame_start;
    logic [2:0]      nbytes;
    logic [7:0][7:0] bytes;
    logic            add_crc;
    logic            has_data;
    logic [7:0]      data_byte;
    logic [7:0]      data_index;
    logic            has_status;
    logic [1:0]      status_kind;
  } job_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mrtu_front.sv -----
// Front end: holds the transaction state and turns accepted words that call for output into jobs.
// Depends on mrtu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire mrtu_pkg::in_t item,
  input  wire logic          cfg_we,
  input  wire logic          cfg_sel,
  input  wire logic [15:0]   cfg_data,
  output logic               job_push,
  output mrtu_pkg::job_t     job
);
  import mrtu_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WAIT    = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  logic [7:0]  slave_id;
  logic [15:0] timeout_ticks;
  logic [1:0]  phase, phase_next;
  logic        op_read, op_read_next;
  logic [7:0]  rx_count, rx_count_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [6:0]  words_left, words_left_next;
  logic [15:0] tick_count, tick_count_next;
  logic [6:0]  n;
  logic [15:0] tick_inc;

  always_comb begin
    if (item.reg_count == 7'd0) begin
      n = 7'd1;
    end else if (item.reg_count > CNT_LIM) begin
      n = CNT_LIM;
    end else begin
      n = item.reg_count;
    end
    tick_inc = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
    phase_next = phase;
    op_read_next = op_read;
    rx_count_next = rx_count;
    expected_length_next = expected_length;
    words_left_next = words_left;
    tick_count_next = tick_count;
    job = '0;
    job_push = 1'b0;
    if (accept) begin
      unique case (item.mode) inside
        MODE_READ, MODE_SINGLE, MODE_MULTI: begin
          if (phase == PH_IDLE) begin
            job.is_tx = 1'b1;
            job.frame_start = 1'b1;
            job.bytes[0] = slave_id;
            job.bytes[2] = item.start_addr[15:8];
            job.bytes[3] = item.start_addr[7:0];
            rx_count_next = 8'd0;
            tick_count_next = 16'd0;
            job_push = 1'b1;
            op_read_next = (item.mode == MODE_READ);
            if (item.mode == MODE_READ) begin
              job.bytes[1] = FUNC_READ;
              job.bytes[4] = 8'h00;
              job.bytes[5] = {1'b0, n};
              job.nbytes = 3'd6;
              job.add_crc = 1'b1;
              expected_length_next = 8'd5 + {n, 1'b0};
              phase_next = PH_WAIT;
            end else if (item.mode == MODE_SINGLE) begin
              job.bytes[1] = FUNC_SINGLE;
              job.bytes[4] = item.word_value[15:8];
              job.bytes[5] = item.word_value[7:0];
              job.nbytes = 3'd6;
              job.add_crc = 1'b1;
              expected_length_next = 8'd8;
              phase_next = PH_WAIT;
            end else begin
              job.bytes[1] = FUNC_MULTI;
              job.bytes[4] = 8'h00;
              job.bytes[5] = {1'b0, n};
              job.bytes[6] = {n, 1'b0};
              job.nbytes = 3'd7;
              words_left_next = n;
              expected_length_next = 8'd8;
              phase_next = PH_COLLECT;
            end
          end
        end
        MODE_WORD: begin
          if (phase == PH_COLLECT) begin
            job.is_tx = 1'b1;
            job.bytes[0] = item.word_value[15:8];
            job.bytes[1] = item.word_value[7:0];
            job.nbytes = 3'd2;
            words_left_next = words_left - 7'd1;
            if (words_left == 7'd1) begin
              job.add_crc = 1'b1;
              phase_next = PH_WAIT;
            end
            job_push = 1'b1;
          end
        end
        MODE_RX: begin
          if (phase == PH_WAIT) begin
            rx_count_next = rx_count + 8'd1;
            if (op_read && rx_count >= 8'd3 && rx_count < expected_length - 8'd2) begin
              job.has_data = 1'b1;
              job.data_byte = item.rx_byte;
              job.data_index = rx_count - 8'd3;
            end
            if (rx_count_next >= expected_length) begin
              job.has_status = 1'b1;
              job.status_kind = KIND_DONE;
              phase_next = PH_IDLE;
            end
            job_push = job.has_data | job.has_status;
          end
        end
        MODE_TICK: begin
          if (phase == PH_WAIT) begin
            tick_count_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              job.has_status = 1'b1;
              job.status_kind = KIND_TIMEOUT;
              phase_next = PH_IDLE;
              job_push = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_id <= 8'd1;
      timeout_ticks <= 16'd10;
      phase <= PH_IDLE;
      op_read <= 1'b0;
      rx_count <= 8'd0;
      expected_length <= 8'd0;
      words_left <= 7'd0;
      tick_count <= 16'd0;
    end else begin
      phase <= phase_next;
      op_read <= op_read_next;
      rx_count <= rx_count_next;
      expected_length <= expected_length_next;
      words_left <= words_left_next;
      tick_count <= tick_count_next;
      if (cfg_we) begin
        case (cfg_sel)
          CFG_SLAVE_ID: slave_id <= cfg_data[7:0];
          default:      timeout_ticks <= cfg_data;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/mrtu_jobq.sv -----
// Two-entry job queue between the front end and the back end.
// Depends on mrtu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_jobq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire mrtu_pkg::job_t wr_job,
  input  wire logic           rd_en,
  output mrtu_pkg::job_t      rd_job,
  output logic                valid,
  output logic                full
);
  import mrtu_pkg::*;

  job_t       entries [2];
  logic       wp, rp;
  logic [1:0] count;

  assign valid = (count != 2'd0);
  assign full = (count == 2'd2);
  assign rd_job = entries[rp];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wp] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wp <= ~wp;
      end
      if (rd_en) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

`default_nettype wire

// ----- sv/mrtu_back.sv -----
// Back end: expands jobs into result words, one a cycle while the two-entry output
// queue holding them has room, keeping frame CRC and position. Depends on mrtu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire mrtu_pkg::job_t job,
  output logic                job_pop,
  input  wire logic           pop,
  output logic                empty,
  output mrtu_pkg::out_t      dout
);
  import mrtu_pkg::*;

  logic [2:0]  step;
  logic [7:0]  tx_position;
  logic [15:0] crc_reg;
  logic [3:0]  total;
  logic        first;
  logic        in_body;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;
  logic [7:0]  pos;
  logic        emit;
  out_t        res;

  out_t       oq [2];
  logic       owp, orp;
  logic [1:0] ocount;

  always_comb begin
    total = job.is_tx ? ({1'b0, job.nbytes} + (job.add_crc ? 4'd2 : 4'd0))
                      : ({3'b000, job.has_data} + {3'b000, job.has_status});
    first = job.frame_start && (step == 3'd0);
    in_body = (step < job.nbytes);
    crc_base = first ? CRC_INIT : crc_reg;
    pos = first ? 8'd0 : tx_position;
    crc_upd = crc_feed(crc_base, job.bytes[step]);
    res = '0;
    if (job.is_tx) begin
      res.kind = KIND_TX;
      res.byte_index = pos;
      if (in_body) begin
        res.byte_value = job.bytes[step];
      end else if (step == job.nbytes) begin
        res.byte_value = crc_reg[7:0];
      end else begin
        res.byte_value = crc_reg[15:8];
      end
    end else if (job.has_data && step == 3'd0) begin
      res.kind = KIND_DATA;
      res.byte_value = job.data_byte;
      res.byte_index = job.data_index;
    end else begin
      res.kind = job.status_kind;
    end
    res.last = ({1'b0, step} == total - 4'd1);
    emit = job_valid && (ocount != 2'd2);
    job_pop = emit && res.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
      tx_position <= 8'd0;
      crc_reg <= CRC_INIT;
    end else if (emit) begin
      if (job.is_tx) begin
        tx_position <= pos + 8'd1;
        if (in_body) begin
          crc_reg <= crc_upd;
        end
      end
      step <= res.last ? 3'd0 : step + 3'd1;
    end
  end

  assign empty = (ocount == 2'd0);
  assign dout = oq[orp];

  always_ff @(posedge clk) begin
    if (emit) begin
      oq[owp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= 1'b0;
      orp <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (emit) begin
        owp <= ~owp;
      end
      if (pop && !empty) begin
        orp <= ~orp;
      end
      ocount <= ocount + {1'b0, emit} - {1'b0, pop && !empty};
    end
  end

endmodule

`default_nettype wire

// ----- sv/modbus_rtu_master_transaction_top.sv -----
// Modbus RTU master top level; depends on mrtu_pkg, mrtu_front, mrtu_jobq, mrtu_back.
// An input word is taken every cycle while full is low; its job is registered in
// the job queue, its results in the output queue. The back end delivers one result
// word a cycle while the output queue has room; a start has up to eight frame bytes.
// Synchronous active-high reset empties both queues and restores the idle state.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_master_transaction_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire mrtu_pkg::in_t din,
  output logic               empty,
  input  wire logic          pop,
  output mrtu_pkg::out_t     dout,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import mrtu_pkg::*;

  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic jq_valid;
  logic jq_full;
  logic job_pop;

  assign cfg_ready = 1'b1;
  assign full = jq_full;
  assign accept = push && !jq_full;

  mrtu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (din),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_sel  (cfg_index),
    .cfg_data (cfg_data),
    .job_push (job_push),
    .job      (job_in)
  );

  mrtu_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job_in),
    .rd_en  (job_pop),
    .rd_job (job_out),
    .valid  (jq_valid),
    .full   (jq_full)
  );

  mrtu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (jq_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .dout      (dout)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !jq_full)
    else $error("job written into a full queue");

  a_job_has_results: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (job_in.is_tx ? (job_in.nbytes != 3'd0 || job_in.add_crc)
                               : (job_in.has_data || job_in.has_status)))
    else $error("job queued that gives no result");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> jq_valid)
    else $error("job retired from an empty queue");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

`default_nettype wire
